[src/line_rasterizer_assert.svh]
// ----------------------------------------------------------------------------
// Line rasteriser assertion macros
// Concurrent checks on the clock with a synchronous active-high reset.
// Bodies are empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH
`ifndef SYNTH
`define LRAST_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lrast check failed");
`define LRAST_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lrast check failed");
`else
`define LRAST_ASSERT_IMPL(name, clk, rst, ante, cons)
`define LRAST_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[src/lrast_pkg.sv]
// ----------------------------------------------------------------------------
// Line rasteriser package
// Command codes and fixed sizes shared by the rasteriser modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lrast_pkg;

   typedef enum logic {
      CMD_START = 1'b0,
      CMD_STEP  = 1'b1
   } cmd_type;

   localparam int COLOR_BITS     = 16;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = 2;

endpackage

`default_nettype wire

[src/lrast_front.sv]
// ----------------------------------------------------------------------------
// Line rasteriser front end
// Accepts items, registers spans and endpoint order, then classifies the
// line (steep, swap, minor direction) and queues an entry for every item.
// ----------------------------------------------------------------------------
`default_nettype none

module lrast_front import lrast_pkg::*; #(
   parameter int COORD_BITS = 10,
   localparam int ENTRY_BITS = 3 + 6 * COORD_BITS + COLOR_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_cmd,
   input  wire logic [COORD_BITS-1:0] req_x_start,
   input  wire logic [COORD_BITS-1:0] req_y_start,
   input  wire logic [COORD_BITS-1:0] req_x_end,
   input  wire logic [COORD_BITS-1:0] req_y_end,
   input  wire logic [COLOR_BITS-1:0] req_line_color,
   output logic                       push_valid,
   input  wire logic                  push_stall,
   output logic [ENTRY_BITS-1:0]      push_data
);

   typedef struct packed {
      cmd_type               cmd;
      logic                  steep;
      logic                  minor_down;
      logic [COORD_BITS-1:0] major_pos;
      logic [COORD_BITS-1:0] minor_pos;
      logic [COORD_BITS-1:0] major_end;
      logic [COORD_BITS-1:0] delta_major;
      logic [COORD_BITS-1:0] delta_minor;
      logic [COORD_BITS-1:0] delta_diff;
      logic [COLOR_BITS-1:0] color;
   } entry_type;

   logic                  valid_ff, valid_in;
   cmd_type               cmd_ff;
   logic [COORD_BITS-1:0] xs_ff, ys_ff, xe_ff, ye_ff;
   logic [COORD_BITS-1:0] dx_ff, dy_ff;
   logic                  x_lt_ff, x_gt_ff, y_lt_ff, y_gt_ff;
   logic [COLOR_BITS-1:0] color_ff;

   logic                  steep, swap, minor_lt, minor_gt;
   logic [COORD_BITS-1:0] ma, mb, na, nb, dmaj, dmin;
   entry_type             entry;

   assign req_stall = valid_ff && push_stall;

   always_comb begin
      valid_in = valid_ff;
      if (!req_stall) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // capture spans and endpoint order
   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         cmd_ff   <= cmd_type'(req_cmd);
         xs_ff    <= req_x_start;
         ys_ff    <= req_y_start;
         xe_ff    <= req_x_end;
         ye_ff    <= req_y_end;
         color_ff <= req_line_color;
         x_lt_ff  <= req_x_start < req_x_end;
         x_gt_ff  <= req_x_start > req_x_end;
         y_lt_ff  <= req_y_start < req_y_end;
         y_gt_ff  <= req_y_start > req_y_end;
         dx_ff    <= (req_x_start > req_x_end) ? (req_x_start - req_x_end)
                                               : (req_x_end - req_x_start);
         dy_ff    <= (req_y_start > req_y_end) ? (req_y_start - req_y_end)
                                               : (req_y_end - req_y_start);
      end
   end

   always_comb begin
      steep    = dy_ff > dx_ff;
      ma       = steep ? ys_ff : xs_ff;
      mb       = steep ? ye_ff : xe_ff;
      na       = steep ? xs_ff : ys_ff;
      nb       = steep ? xe_ff : ye_ff;
      minor_lt = steep ? x_lt_ff : y_lt_ff;
      minor_gt = steep ? x_gt_ff : y_gt_ff;
      swap     = steep ? y_gt_ff : x_gt_ff;
      dmaj     = steep ? dy_ff : dx_ff;
      dmin     = steep ? dx_ff : dy_ff;

      entry.cmd         = cmd_ff;
      entry.steep       = steep;
      entry.major_pos   = swap ? mb : ma;
      entry.major_end   = swap ? ma : mb;
      entry.minor_pos   = swap ? nb : na;
      entry.minor_down  = swap ? !minor_gt : !minor_lt;
      entry.delta_major = dmaj;
      entry.delta_minor = dmin;
      entry.delta_diff  = dmaj - dmin;
      entry.color       = color_ff;
   end

   assign push_valid = valid_ff;
   assign push_data  = entry;

endmodule

`default_nettype wire

[src/lrast_queue.sv]
// ----------------------------------------------------------------------------
// Line rasteriser queue
// Small in-order FIFO of setup and step entries between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lrast_queue import lrast_pkg::*; #(
   parameter int COORD_BITS = 10,
   localparam int ENTRY_BITS = 3 + 6 * COORD_BITS + COLOR_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_stall,
   input  wire logic [ENTRY_BITS-1:0] push_data,
   output logic                       pop_valid,
   input  wire logic                  pop_stall,
   output logic [ENTRY_BITS-1:0]      pop_data
);

   logic [ENTRY_BITS-1:0]     slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [QUEUE_PTR_BITS:0]   count_ff, count_in;
   logic                      push, pop;

   assign push_stall = count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && !push_stall;
   assign pop        = pop_valid && !pop_stall;
   assign pop_data   = slot_ff[head_ff];

   always_comb begin
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      tail_in  = push ? tail_ff + 1'b1 : tail_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

[src/lrast_back.sv]
// ----------------------------------------------------------------------------
// Line rasteriser back end
// Holds the Bresenham state, loads it on a start entry and, while a line is
// active, emits one pixel per step entry into a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_rasterizer_assert.svh"

module lrast_back import lrast_pkg::*; #(
   parameter int COORD_BITS = 10,
   localparam int ENTRY_BITS = 3 + 6 * COORD_BITS + COLOR_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output logic                       pop_stall,
   input  wire logic [ENTRY_BITS-1:0] pop_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [COORD_BITS-1:0]      rsp_pixel_x,
   output logic [COORD_BITS-1:0]      rsp_pixel_y,
   output logic [COLOR_BITS-1:0]      rsp_pixel_color,
   output logic                       rsp_last_pixel
);

   localparam int ERR_BITS = COORD_BITS + 2;

   typedef struct packed {
      cmd_type               cmd;
      logic                  steep;
      logic                  minor_down;
      logic [COORD_BITS-1:0] major_pos;
      logic [COORD_BITS-1:0] minor_pos;
      logic [COORD_BITS-1:0] major_end;
      logic [COORD_BITS-1:0] delta_major;
      logic [COORD_BITS-1:0] delta_minor;
      logic [COORD_BITS-1:0] delta_diff;
      logic [COLOR_BITS-1:0] color;
   } entry_type;

   entry_type             entry;
   logic                  busy_ff, busy_in;
   logic                  steep_ff, steep_in;
   logic                  minor_down_ff, minor_down_in;
   logic [COORD_BITS-1:0] major_pos_ff, major_pos_in;
   logic [COORD_BITS-1:0] minor_pos_ff, minor_pos_in;
   logic [COORD_BITS-1:0] major_end_ff, major_end_in;
   logic [COORD_BITS-1:0] delta_minor_ff, delta_minor_in;
   logic [COORD_BITS-1:0] delta_diff_ff, delta_diff_in;
   logic [ERR_BITS-1:0]   error_ff, error_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic [COLOR_BITS-1:0] rsp_color_ff;
   logic                  rsp_last_ff;

   logic                  is_step, produces, out_free, take, load_rsp, last;
   logic [ERR_BITS-1:0]   err_dec, err_inc;

   assign entry     = pop_data;
   assign is_step   = entry.cmd == CMD_STEP;
   assign produces  = is_step && busy_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop_stall = produces && !out_free;
   assign take      = pop_valid && !pop_stall;
   assign load_rsp  = take && produces;
   assign last      = major_pos_ff >= major_end_ff;
   assign err_dec   = error_ff - {2'b00, delta_minor_ff};
   assign err_inc   = error_ff + {2'b00, delta_diff_ff};

   always_comb begin
      busy_in        = busy_ff;
      steep_in       = steep_ff;
      minor_down_in  = minor_down_ff;
      major_pos_in   = major_pos_ff;
      minor_pos_in   = minor_pos_ff;
      major_end_in   = major_end_ff;
      delta_minor_in = delta_minor_ff;
      delta_diff_in  = delta_diff_ff;
      error_in       = error_ff;
      color_in       = color_ff;
      if (take && !is_step) begin
         busy_in        = 1'b1;
         steep_in       = entry.steep;
         minor_down_in  = entry.minor_down;
         major_pos_in   = entry.major_pos;
         minor_pos_in   = entry.minor_pos;
         major_end_in   = entry.major_end;
         delta_minor_in = entry.delta_minor;
         delta_diff_in  = entry.delta_diff;
         error_in       = {3'b000, entry.delta_major[COORD_BITS-1:1]};
         color_in       = entry.color;
      end else if (load_rsp) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + COORD_BITS'(1);
            if (err_dec[ERR_BITS-1]) begin
               error_in     = err_inc;
               minor_pos_in = minor_down_ff ? minor_pos_ff - COORD_BITS'(1)
                                            : minor_pos_ff + COORD_BITS'(1);
            end else begin
               error_in = err_dec;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      steep_ff       <= steep_in;
      minor_down_ff  <= minor_down_in;
      major_pos_ff   <= major_pos_in;
      minor_pos_ff   <= minor_pos_in;
      major_end_ff   <= major_end_in;
      delta_minor_ff <= delta_minor_in;
      delta_diff_ff  <= delta_diff_in;
      error_ff       <= error_in;
      color_ff       <= color_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_x_ff     <= steep_ff ? minor_pos_ff : major_pos_ff;
         rsp_y_ff     <= steep_ff ? major_pos_ff : minor_pos_ff;
         rsp_color_ff <= color_ff;
         rsp_last_ff  <= last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_last_pixel  = rsp_last_ff;

   `LRAST_ASSERT_NEXT(a_last_ends_line, clock, reset, load_rsp && last, !busy_ff)
   `LRAST_ASSERT_IMPL(a_error_nonneg, clock, reset, busy_ff, !error_ff[ERR_BITS-1])
   `LRAST_ASSERT_NEXT(a_major_advance, clock, reset, load_rsp && !last, major_pos_ff == $past(major_pos_ff + COORD_BITS'(1)))

endmodule

`default_nettype wire

[src/line_rasterizer.sv]
// ----------------------------------------------------------------------------
// Line rasteriser
// Bresenham line pixel generator with a start/step item interface.
// ----------------------------------------------------------------------------
// A start item (cmd 0) loads two endpoints and a colour and emits nothing; a
// step item (cmd 1) emits one pixel of the active line, the final one marked
// by last_pixel, and a step with no active line is dropped. A start replaces
// any line still in progress. The block takes one item per clock and gives
// one pixel per clock while no stall holds it: each pixel is a single
// error-term update in the back end. A start passes a registered setup
// stage and a four-entry queue before it reaches the stepping state, so
// items queue behind it without a stall; a step's pixel passes the setup
// register, the queue and the output register before rsp_valid rises.
// Results come from an output register, so the input keeps flowing while a
// pixel waits to be taken, until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer import lrast_pkg::*; #(
   parameter int COORD_BITS = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_cmd,
   input  wire logic [COORD_BITS-1:0] req_x_start,
   input  wire logic [COORD_BITS-1:0] req_y_start,
   input  wire logic [COORD_BITS-1:0] req_x_end,
   input  wire logic [COORD_BITS-1:0] req_y_end,
   input  wire logic [COLOR_BITS-1:0] req_line_color,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [COORD_BITS-1:0]      rsp_pixel_x,
   output logic [COORD_BITS-1:0]      rsp_pixel_y,
   output logic [COLOR_BITS-1:0]      rsp_pixel_color,
   output logic                       rsp_last_pixel
);

   localparam int ENTRY_BITS = 3 + 6 * COORD_BITS + COLOR_BITS;

   logic                  push_valid, push_stall, pop_valid, pop_stall;
   logic [ENTRY_BITS-1:0] push_data, pop_data;

   lrast_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_line_color (req_line_color),
      .push_valid     (push_valid),
      .push_stall     (push_stall),
      .push_data      (push_data)
   );

   lrast_queue #(.COORD_BITS(COORD_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_stall (push_stall),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_data   (pop_data)
   );

   lrast_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_stall       (pop_stall),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_pixel  (rsp_last_pixel)
   );

endmodule

`default_nettype wire

[tb/tb_line_rasterizer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasteriser testbench
// Drives start and step items with bursty valid and random result stall.
// A cycle-free line stepper predicts each pixel, or a directed row gives it,
// and every taken pixel is compared in order against it. A directed table
// runs first, then random lines, noise, and truncated and overlong lines.
// ----------------------------------------------------------------------------

module tb_line_rasterizer;
   import lrast_pkg::*;

   localparam int COORD_BITS = 10;
   localparam int COORD_MAX  = (1 << COORD_BITS) - 1;
   localparam int WORK_ITEMS = 1750;
   localparam int NUM_ROWS   = 25;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef struct packed {
      cmd_type   cmd;
      coord_type xs;
      coord_type ys;
      coord_type xe;
      coord_type ye;
      color_type color;
   } req_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      color_type color;
      logic      last;
   } pixel_type;

   typedef struct packed {
      cmd_type   cmd;
      coord_type xs;
      coord_type ys;
      coord_type xe;
      coord_type ye;
      color_type color;
      logic      typed;
      coord_type ex;
      coord_type ey;
      color_type ec;
      logic      el;
   } row_type;

   logic      clock          = 1'b0;
   logic      reset          = 1'b1;
   logic      req_valid      = 1'b0;
   logic      req_cmd        = 1'b0;
   coord_type req_x_start    = '0;
   coord_type req_y_start    = '0;
   coord_type req_x_end      = '0;
   coord_type req_y_end      = '0;
   color_type req_line_color = '0;
   logic      rsp_stall      = 1'b0;
   wire       req_stall;
   wire       rsp_valid;
   coord_type rsp_pixel_x;
   coord_type rsp_pixel_y;
   color_type rsp_pixel_color;
   wire       rsp_last_pixel;

   line_rasterizer #(.COORD_BITS(COORD_BITS)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_x_start    (req_x_start),
      .req_y_start    (req_y_start),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_line_color (req_line_color),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_x    (rsp_pixel_x),
      .rsp_pixel_y    (rsp_pixel_y),
      .rsp_pixel_color(rsp_pixel_color),
      .rsp_last_pixel (rsp_last_pixel)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // line stepper state
   logic               line_busy   = 1'b0;
   logic               line_steep  = 1'b0;
   coord_type          major_pos   = '0;
   coord_type          minor_pos   = '0;
   coord_type          major_end   = '0;
   coord_type          delta_major = '0;
   coord_type          delta_minor = '0;
   logic signed [11:0] step_error  = '0;
   logic               minor_down  = 1'b0;
   color_type          line_color  = '0;

   pixel_type pending_pixels [$];
   int        mismatch_count = 0;
   int        work_items     = 0;
   int        burst_left     = 0;
   logic      drain_quiet    = 1'b0;
   row_type   directed_rows [NUM_ROWS];

   function automatic coord_type span(input coord_type a, input coord_type b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic rasterize_step(input req_type item, output pixel_type px);
      coord_type ma, na, mb, nb, sw;
      logic      is_last;
      px = '0;
      if (item.cmd == CMD_START) begin
         line_steep = span(item.ys, item.ye) > span(item.xs, item.xe);
         if (line_steep) begin
            ma = item.ys; na = item.xs; mb = item.ye; nb = item.xe;
         end else begin
            ma = item.xs; na = item.ys; mb = item.xe; nb = item.ye;
         end
         if (ma > mb) begin
            sw = ma; ma = mb; mb = sw;
            sw = na; na = nb; nb = sw;
         end
         major_pos   = ma;
         minor_pos   = na;
         major_end   = mb;
         delta_major = mb - ma;
         delta_minor = span(na, nb);
         step_error  = $signed({3'b000, delta_major[COORD_BITS-1:1]});
         minor_down  = !(na < nb);
         line_color  = item.color;
         line_busy   = 1'b1;
         return 1'b0;
      end
      if (!line_busy)
         return 1'b0;
      is_last  = major_pos >= major_end;
      px.x     = line_steep ? minor_pos : major_pos;
      px.y     = line_steep ? major_pos : minor_pos;
      px.color = line_color;
      px.last  = is_last;
      if (is_last) begin
         line_busy = 1'b0;
      end else begin
         step_error = step_error - $signed({2'b00, delta_minor});
         if (step_error < 0) begin
            minor_pos  = minor_down ? minor_pos - 1'b1 : minor_pos + 1'b1;
            step_error = step_error + $signed({2'b00, delta_major});
         end
         major_pos = major_pos + 1'b1;
      end
      return 1'b1;
   endfunction

   task automatic send_item(input req_type item, input logic typed,
                            input pixel_type typed_px);
      int        gap;
      pixel_type px;
      logic      has_px;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_cmd        <= item.cmd;
      req_x_start    <= item.xs;
      req_y_start    <= item.ys;
      req_x_end      <= item.xe;
      req_y_end      <= item.ye;
      req_line_color <= item.color;
      do @(posedge clock); while (req_stall);
      has_px = rasterize_step(item, px);
      if (has_px)
         pending_pixels.push_back(typed ? typed_px : px);
      work_items++;
   endtask

   task automatic wait_for_pixels();
      do @(posedge clock); while (pending_pixels.size() != 0);
   endtask

   function automatic coord_type pick_coord();
      if ($urandom_range(0, 7) == 0)
         return $urandom_range(0, 1) ? coord_type'(COORD_MAX) : coord_type'(0);
      return coord_type'($urandom_range(0, COORD_MAX));
   endfunction

   function automatic coord_type near_coord(input coord_type a);
      int t;
      t = int'(a) + $urandom_range(0, 24) - 12;
      if (t < 0) t = 0;
      if (t > COORD_MAX) t = COORD_MAX;
      return coord_type'(t);
   endfunction

   // result stall: modes of none, light, heavy and long runs
   int   stall_mode = 0;
   int   mode_left  = 0;
   int   run_left   = 0;
   logic run_level  = 1'b0;

   always @(posedge clock) begin
      if (reset || drain_quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(16, 96);
         end
         mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            2: rsp_stall <= $urandom_range(0, 1);
            default: begin
               if (run_left == 0) begin
                  run_level = !run_level;
                  run_left  = $urandom_range(1, 12);
               end
               run_left--;
               rsp_stall <= run_level;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      pixel_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_pixel_x, rsp_pixel_y, rsp_pixel_color, rsp_last_pixel};
         if (pending_pixels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected pixel x=%0d y=%0d colour=%h last=%b",
                        got.x, got.y, got.color, got.last);
         end else begin
            want = pending_pixels.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"pixel mismatch: expected x=%0d y=%0d colour=%h last=%b,",
                            " got x=%0d y=%0d colour=%h last=%b"},
                           want.x, want.y, want.color, want.last,
                           got.x, got.y, got.color, got.last);
            end
         end
      end
   end

   initial begin
      #4ms;
      $display("tb_line_rasterizer failed");
      $finish;
   end

   initial begin
      req_type   item;
      pixel_type px;
      coord_type xa, ya, xb, yb;
      int        major, steps, pick;
      int        next_flush;

      directed_rows = '{
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 0,    0,    0, 16'h0000, 0},
         '{CMD_START,    0,    0,    0,    0, 16'h0000, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 1,    0,    0, 16'h0000, 1},
         '{CMD_STEP,  1023, 1023, 1023, 1023, 16'hffff, 0,    0,    0, 16'h0000, 0},
         '{CMD_START, 1023, 1023, 1023, 1023, 16'hffff, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 1, 1023, 1023, 16'hffff, 1},
         '{CMD_START,    3,    5,    0,    5, 16'h1234, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 1,    0,    5, 16'h1234, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 1,    1,    5, 16'h1234, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 1,    2,    5, 16'h1234, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 1,    3,    5, 16'h1234, 1},
         '{CMD_START,    7, 1023,    7, 1020, 16'h8001, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 1,    7, 1020, 16'h8001, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 1,    7, 1021, 16'h8001, 0},
         '{CMD_START,    0, 1023, 1023,    0, 16'haaaa, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,  1023,    0, 1023,    0, 16'hffff, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 0,    0,    0, 16'h0000, 0},
         '{CMD_START,    2,    0,    9,    3, 16'h5555, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 0,    0,    0, 16'h0000, 0},
         '{CMD_START,   10,    0,    8,    6, 16'h0f0f, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 0,    0,    0, 16'h0000, 0},
         '{CMD_STEP,     0,    0,    0,    0, 16'h0000, 0,    0,    0, 16'h0000, 0}
      };

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         item = '{directed_rows[i].cmd, directed_rows[i].xs, directed_rows[i].ys,
                  directed_rows[i].xe, directed_rows[i].ye, directed_rows[i].color};
         px   = '{directed_rows[i].ex, directed_rows[i].ey, directed_rows[i].ec,
                  directed_rows[i].el};
         send_item(item, directed_rows[i].typed, px);
      end

      // hold the sender until the directed pixels are all back
      req_valid  <= 1'b0;
      burst_left = 0;
      wait_for_pixels();
      next_flush = work_items + 400;

      while (work_items < WORK_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 6) begin
            item = '{cmd_type'($urandom_range(0, 1)), coord_type'($urandom),
                     coord_type'($urandom), coord_type'($urandom), coord_type'($urandom),
                     color_type'($urandom)};
            send_item(item, 1'b0, '0);
         end else begin
            xa = pick_coord();
            ya = pick_coord();
            if (pick < 10) begin
               xb = coord_type'($urandom);
               yb = coord_type'($urandom);
            end else begin
               xb = near_coord(xa);
               yb = near_coord(ya);
            end
            major = (span(xa, xb) > span(ya, yb)) ? span(xa, xb) : span(ya, yb);
            steps = major + 1;
            if (steps > 60)
               steps = $urandom_range(1, 60);
            pick = $urandom_range(0, 99);
            if (pick < 15)
               steps = $urandom_range(0, steps - 1);
            else if (pick < 30)
               steps = steps + $urandom_range(1, 3);
            item = '{CMD_START, xa, ya, xb, yb, color_type'($urandom)};
            send_item(item, 1'b0, '0);
            repeat (steps) begin
               item = '{CMD_STEP, coord_type'($urandom), coord_type'($urandom),
                        coord_type'($urandom), coord_type'($urandom),
                        color_type'($urandom)};
               send_item(item, 1'b0, '0);
            end
         end
         if (work_items >= next_flush) begin
            req_valid  <= 1'b0;
            burst_left = 0;
            wait_for_pixels();
            next_flush = next_flush + 400;
         end
      end

      req_valid <= 1'b0;
      wait_for_pixels();
      drain_quiet = 1'b1;
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && pending_pixels.size() == 0)
         $display("tb_line_rasterizer passed");
      else
         $display("tb_line_rasterizer failed");
      $finish;
   end

endmodule
